// ----- rtl/pwf_pkg.sv -----
// Package for the phonetic word finder: status codes, register indexes,
// configuration struct and the letter-group folding function. No dependencies.
package pwf_pkg;

  localparam int unsigned PatChars   = 16;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned LenBits    = 5;
  localparam int unsigned ApbDataW   = 64;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned WordStartW = 32;

  localparam logic [CharBits-1:0] SpaceChar = 8'h20;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_EMPTY_ARG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [PatChars*CharBits-1:0] pattern;
    logic [LenBits-1:0]           length;
  } cfg_t;

  // Fold case and merge the letter groups onto one representative each.
  function automatic logic [CharBits-1:0] phon_class(input logic [CharBits-1:0] c);
    logic [CharBits-1:0] lc;
    lc = c;
    if (c >= "A" && c <= "Z") begin
      lc = c + 8'h20;
    end
    case (lc)
      "v":      phon_class = "w";
      "j":      phon_class = "g";
      "z":      phon_class = "s";
      "t":      phon_class = "d";
      "u":      phon_class = "o";
      "y":      phon_class = "i";
      "k", "q": phon_class = "c";
      "p", "f": phon_class = "b";
      default:  phon_class = lc;
    endcase
  endfunction

endpackage

// ----- rtl/phonetic_word_finder.sv -----
// Top level of the phonetic word finder: APB pattern registers and search core.
// Depends on pwf_pkg, pwf_cfg and pwf_core.

// Takes one text byte per cycle, back to back. A result appears in the output
// register the cycle after the byte that causes it. A new byte is taken in the
// same cycle that a waiting result is taken, so the input stalls only while the
// receiver holds a result back. The per-byte state update (position, word start,
// character count, mismatch flag) is registered as each byte is taken. Program
// the pattern over APB only while no text is in flight.
module phonetic_word_finder import pwf_pkg::*; #(
  parameter int unsigned MAX_PATTERN_CHARS = 16,
  parameter int unsigned POSITION_BITS     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready,
  input  logic                  text_valid_i,
  output logic                  text_ready_o,
  input  logic [CharBits-1:0]   text_char_i,
  input  logic                  last_char_i,
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output logic [1:0]            status_o,
  output logic [WordStartW-1:0] word_start_o
);

  cfg_t cfg;

  pwf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwf_core #(
    .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS),
    .POSITION_BITS     (POSITION_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .text_valid_i   (text_valid_i),
    .text_ready_o   (text_ready_o),
    .text_char_i    (text_char_i),
    .last_char_i    (last_char_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .status_o       (status_o),
    .word_start_o   (word_start_o)
  );

endmodule

// ----- rtl/pwf_cfg.sv -----
// APB register file for the pattern (two 64-bit character words and length).
// Depends on pwf_pkg.
module pwf_cfg import pwf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [ApbDataW-1:0] pat_low_q, pat_high_q;
  logic [LenBits-1:0]  pat_len_q;
  logic                wr_en;
  reg_idx_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PAT_LOW:  pat_low_q  <= pwdata;
        REG_PAT_HIGH: pat_high_q <= pwdata;
        REG_PAT_LEN:  pat_len_q  <= pwdata[LenBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAT_LOW:  prdata = pat_low_q;
      REG_PAT_HIGH: prdata = pat_high_q;
      REG_PAT_LEN:  prdata = {{(ApbDataW-LenBits){1'b0}}, pat_len_q};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.pattern = {pat_high_q, pat_low_q};
  assign cfg_o.length  = pat_len_q;

endmodule

// ----- rtl/pwf_core.sv -----
// Per-byte word tracking, phonetic compare and result register.
// Depends on pwf_pkg; pattern comes from pwf_cfg.
module pwf_core import pwf_pkg::*; #(
  parameter int unsigned MAX_PATTERN_CHARS = 16,
  parameter int unsigned POSITION_BITS     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  text_valid_i,
  output logic                  text_ready_o,
  input  logic [CharBits-1:0]   text_char_i,
  input  logic                  last_char_i,
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output logic [1:0]            status_o,
  output logic [WordStartW-1:0] word_start_o
);

  localparam logic [LenBits-1:0] MaxLen = LenBits'(MAX_PATTERN_CHARS);

  logic [POSITION_BITS-1:0] pos_q, pos_d, cws_q, cws_d, start_w;
  logic [LenBits-1:0]       cnt_q, cnt_d, cnt_inc, plen;
  logic                     mm_q, mm_d, mm_nxt, done_q, done_d;
  logic                     out_vld_q;
  status_e                  status_q, status_d;
  logic [WordStartW-1:0]    wstart_q, wstart_d;

  logic                acc, is_sp, err, active, word_end, match, found, nf, res_fire;
  logic [CharBits-1:0] pchar, pchar0;

  assign acc          = text_valid_i && text_ready_o;
  assign text_ready_o = !out_vld_q || result_ready_i;

  assign plen   = (cfg_i.length > MaxLen) ? MaxLen : cfg_i.length;
  assign pchar0 = cfg_i.pattern[CharBits-1:0];
  assign pchar  = cfg_i.pattern[cnt_q[3:0]*CharBits +: CharBits];
  assign is_sp  = (text_char_i == SpaceChar);

  assign err = !done_q && (pos_q == '0) &&
               ((plen == '0) || ((plen == LenBits'(1)) && (pchar0 == SpaceChar)) ||
                (is_sp && last_char_i));
  assign active = !(done_q || err);

  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + LenBits'(1);
  assign mm_nxt  = mm_q || (cnt_q >= plen) ||
                   (phon_class(text_char_i) != phon_class(pchar));
  assign start_w = (cnt_q == '0) ? pos_q : cws_q;

  assign word_end = is_sp || last_char_i;
  assign match    = is_sp ? ((cnt_q == plen) && !mm_q) : ((cnt_inc == plen) && !mm_nxt);
  assign found    = active && word_end && match;
  assign nf       = active && !found && last_char_i;
  assign res_fire = acc && (err || found || nf);

  always_comb begin
    pos_d  = pos_q;
    cws_d  = cws_q;
    cnt_d  = cnt_q;
    mm_d   = mm_q;
    done_d = done_q;
    if (acc) begin
      if (last_char_i) begin
        pos_d  = '0;
        cws_d  = '0;
        cnt_d  = '0;
        mm_d   = 1'b0;
        done_d = 1'b0;
      end else begin
        pos_d  = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
        done_d = done_q || err || found;
        if (active) begin
          if (is_sp) begin
            cnt_d = '0;
            mm_d  = 1'b0;
          end else begin
            cws_d = start_w;
            cnt_d = cnt_inc;
            mm_d  = mm_nxt;
          end
        end
      end
    end
  end

  always_comb begin
    if (err) begin
      status_d = STATUS_EMPTY_ARG;
      wstart_d = '0;
    end else if (found) begin
      status_d = STATUS_FOUND;
      wstart_d = WordStartW'(start_w);
    end else begin
      status_d = STATUS_NOT_FOUND;
      wstart_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cws_q     <= '0;
      cnt_q     <= '0;
      mm_q      <= 1'b0;
      done_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      cws_q  <= cws_d;
      cnt_q  <= cnt_d;
      mm_q   <= mm_d;
      done_q <= done_d;
      if (res_fire) begin
        out_vld_q <= 1'b1;
      end else if (result_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      status_q <= status_d;
      wstart_q <= wstart_d;
    end
  end

  assign result_valid_o = out_vld_q;
  assign status_o       = status_q;
  assign word_start_o   = wstart_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_char_i |=> (pos_q == '0) && !done_q && (cnt_q == '0))
    else $error("state not cleared after last beat");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && done_q && !last_char_i |-> !res_fire)
    else $error("result after search finished");

  a_empty_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !mm_q)
    else $error("mismatch flag set with no characters");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (status_q == STATUS_FOUND) || (status_q == STATUS_NOT_FOUND) ||
                  (status_q == STATUS_EMPTY_ARG))
    else $error("illegal status code");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for phonetic_word_finder: a directed table, then random texts.
// Each result beat is checked against an in-bench search predictor, or for typed rows
// against the table, while both sides idle at random. Depends on pwf_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pwf_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned RandomBeats = 1700;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned TimeLimit   = 10_000_000;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] word_start;
  } search_result_t;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    addr_idx;
    logic [63:0] value;
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    status_e     st;
    logic [31:0] ws;
  } dir_row_t;

  localparam dir_row_t DirRows [27] = '{
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "a",   1'b1, 1'b1, STATUS_EMPTY_ARG, 32'd0},
    '{ROW_CFG,  REG_PAT_LOW,  64'h20,     8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_CFG,  REG_PAT_LEN,  64'd1,      8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "x",   1'b1, 1'b1, STATUS_EMPTY_ARG, 32'd0},
    '{ROW_CFG,  REG_PAT_LOW,  64'h746163, 8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_CFG,  REG_PAT_LEN,  64'd3,      8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      8'h20, 1'b1, 1'b1, STATUS_EMPTY_ARG, 32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "K",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "A",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "D",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      " ",   1'b0, 1'b1, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "d",   1'b1, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "a",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "b",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      " ",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "q",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "A",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "d",   1'b1, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "x",   1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "x",   1'b1, 1'b1, STATUS_NOT_FOUND, 32'd0},
    '{ROW_CFG,  REG_PAT_LOW,  64'hFF,     8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_CFG,  REG_PAT_HIGH, '1,         8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_CFG,  REG_PAT_LEN,  64'd2,      8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      8'hFF, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      8'h00, 1'b1, 1'b1, STATUS_FOUND,     32'd0},
    '{ROW_CFG,  REG_PAT_LEN,  64'd31,     8'h00, 1'b0, 1'b0, STATUS_FOUND,     32'd0},
    '{ROW_BYTE, REG_PAT_LOW,  64'd0,      "a",   1'b1, 1'b1, STATUS_NOT_FOUND, 32'd0}
  };

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [ApbAddrW-1:0]   paddr          = '0;
  logic [ApbDataW-1:0]   pwdata         = '0;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;
  logic                  text_valid_i   = 1'b0;
  logic                  text_ready_o;
  logic [CharBits-1:0]   text_char_i    = '0;
  logic                  last_char_i    = 1'b0;
  logic                  result_valid_o;
  logic                  result_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [WordStartW-1:0] word_start_o;

  phonetic_word_finder i_dut (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // predictor copy of the registers and search state
  logic [63:0] cfg_pat_low  = '0;
  logic [63:0] cfg_pat_high = '0;
  logic [4:0]  cfg_pat_len  = '0;
  logic [31:0] pos_cnt        = '0;
  logic [31:0] cur_word_start = '0;
  logic [4:0]  word_len       = '0;
  logic        word_miss      = 1'b0;
  logic        text_done      = 1'b0;

  search_result_t pending_results[$];
  int unsigned    mismatches  = 0;
  int unsigned    beats_taken = 0;
  int unsigned    burst_left  = 0;

  logic [7:0]  pat_chars [16];
  int unsigned pat_eff;
  logic [7:0]  text_buf[$];

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    case (lc)
      "v":      return "w";
      "j":      return "g";
      "z":      return "s";
      "t":      return "d";
      "u":      return "o";
      "y":      return "i";
      "k", "q": return "c";
      "p", "f": return "b";
      default:  return lc;
    endcase
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) begin
      c = c - 8'h20;
    end
    return c;
  endfunction

  // any byte in the same letter group as c, either case
  function automatic logic [7:0] pick_alike(input logic [7:0] c);
    logic [7:0] alike[$];
    for (int v = 0; v < 256; v++) begin
      if (fold_char(8'(v)) == fold_char(c)) begin
        alike.push_back(8'(v));
      end
    end
    return alike[$urandom_range(0, alike.size() - 1)];
  endfunction

  task automatic search_step(input logic [7:0] ch, input logic last, output logic hit,
                             output search_result_t res);
    logic [4:0]   plen;
    logic [127:0] pat;
    logic         word_end;
    plen     = (cfg_pat_len > 5'd16) ? 5'd16 : cfg_pat_len;
    pat      = {cfg_pat_high, cfg_pat_low};
    hit      = 1'b0;
    res      = '{STATUS_FOUND, 32'd0};
    word_end = 1'b0;
    if (!text_done && pos_cnt == 0) begin
      if (plen == 0 || (plen == 1 && pat[7:0] == SpaceChar) || (ch == SpaceChar && last)) begin
        hit       = 1'b1;
        res       = '{STATUS_EMPTY_ARG, 32'd0};
        text_done = 1'b1;
      end
    end
    if (!text_done) begin
      if (ch == SpaceChar) begin
        word_end = 1'b1;
      end else begin
        if (word_len == 0) begin
          cur_word_start = pos_cnt;
        end
        if (word_len >= plen || fold_char(ch) != fold_char(pat[word_len[3:0]*8 +: 8])) begin
          word_miss = 1'b1;
        end
        if (word_len != 5'd31) begin
          word_len++;
        end
        if (last) begin
          word_end = 1'b1;
        end
      end
      if (word_end) begin
        if (word_len == plen && !word_miss) begin
          hit       = 1'b1;
          res       = '{STATUS_FOUND, cur_word_start};
          text_done = 1'b1;
        end
        word_len  = '0;
        word_miss = 1'b0;
      end
      if (!text_done && last) begin
        hit = 1'b1;
        res = '{STATUS_NOT_FOUND, 32'd0};
      end
    end
    if (pos_cnt != '1) begin
      pos_cnt++;
    end
    if (last) begin
      pos_cnt        = '0;
      cur_word_start = '0;
      word_len       = '0;
      word_miss      = 1'b0;
      text_done      = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PAT_LOW:  cfg_pat_low  = value;
      REG_PAT_HIGH: cfg_pat_high = value;
      default:      cfg_pat_len  = value[4:0];
    endcase
    @(posedge clk_i);
  endtask

  // one text beat; the sender idles between bursts of random length
  task automatic send_beat(input logic [7:0] ch, input logic last, input logic typed,
                           input search_result_t typed_res);
    search_result_t res;
    logic           hit;
    text_valid_i <= 1'b1;
    text_char_i  <= ch;
    last_char_i  <= last;
    do @(posedge clk_i); while (!text_ready_o);
    beats_taken++;
    search_step(ch, last, hit, res);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else if (hit) begin
      pending_results.push_back(res);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      text_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic wait_idle(input int unsigned extra);
    text_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic fill_text();
    int unsigned ws;
    text_buf.delete();
    if ($urandom_range(0, 29) == 0) begin
      text_buf.push_back(SpaceChar);
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      repeat ($urandom_range(0, 2)) text_buf.push_back(SpaceChar);
      ws = text_buf.size();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          for (int i = 0; i < pat_eff; i++) text_buf.push_back(pick_alike(pat_chars[i]));
        end
        9, 10, 11, 12: begin
          for (int i = 0; i < pat_eff; i++) text_buf.push_back(pick_alike(pat_chars[i]));
          case ($urandom_range(0, 2))
            0: begin
              if (text_buf.size() > ws) begin
                text_buf[$urandom_range(ws, text_buf.size() - 1)] = random_letter();
              end
            end
            1: text_buf.push_back(random_letter());
            default: begin
              if (text_buf.size() > ws) begin
                void'(text_buf.pop_back());
              end
            end
          endcase
        end
        13, 14, 15: begin
          repeat ($urandom_range(1, 8)) text_buf.push_back(random_letter());
        end
        16, 17, 18: begin
          repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          // long word: the character count saturates
          repeat ($urandom_range(30, 40)) text_buf.push_back(random_letter());
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      text_buf.push_back(SpaceChar);
    end
    if (text_buf.size() == 0) begin
      text_buf.push_back(random_letter());
    end
  endtask

  task automatic set_random_pattern();
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  plen;
    for (int i = 0; i < 16; i++) pat_chars[i] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 15))
      0: plen = 5'd0;
      1: begin
        plen         = 5'd1;
        pat_chars[0] = SpaceChar;
      end
      2: begin
        plen = 5'($urandom_range(17, 31));
        for (int i = 0; i < 16; i++) pat_chars[i] = random_letter();
      end
      3: begin
        plen = 5'd16;
        for (int i = 0; i < 16; i++) pat_chars[i] = random_letter();
      end
      4: begin
        plen = 5'($urandom_range(2, 5));
        for (int i = 0; i < 16; i++) pat_chars[i] = random_letter();
        pat_chars[$urandom_range(0, plen - 1)] = SpaceChar;
      end
      5: plen = 5'($urandom_range(1, 4));
      default: begin
        plen = 5'($urandom_range(1, 6));
        for (int i = 0; i < 16; i++) pat_chars[i] = random_letter();
      end
    endcase
    pat_eff = (plen > 5'd16) ? 16 : plen;
    for (int i = 0; i < 8; i++) begin
      low[i*8 +: 8]  = pat_chars[i];
      high[i*8 +: 8] = pat_chars[i+8];
    end
    apb_write(REG_PAT_LOW, low);
    apb_write(REG_PAT_HIGH, high);
    apb_write(REG_PAT_LEN, {32'($urandom()), 27'($urandom()), plen});
  endtask

  initial begin : stimulus
    int unsigned rand_start;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(0, 40);
    foreach (DirRows[i]) begin
      if (DirRows[i].kind == ROW_CFG) begin
        wait_idle(DrainCycles);
        apb_write(DirRows[i].addr_idx, DirRows[i].value);
      end else begin
        send_beat(DirRows[i].ch, DirRows[i].last, DirRows[i].typed,
                  '{DirRows[i].st, DirRows[i].ws});
      end
    end
    rand_start = beats_taken;
    while (beats_taken - rand_start < RandomBeats) begin
      // every pattern change waits for the block to drain
      wait_idle(DrainCycles);
      set_random_pattern();
      repeat ($urandom_range(3, 10)) begin
        fill_text();
        foreach (text_buf[i]) begin
          send_beat(text_buf[i], i == text_buf.size() - 1, 1'b0, '{STATUS_FOUND, 32'd0});
        end
      end
    end
    wait_idle(20);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: stall modes change at random, one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    bit          held;
    logic [15:0] stall_pat;
    mode      = 0;
    left      = 0;
    held      = 1'b0;
    stall_pat = '1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && beats_taken >= 500) begin
        held = 1'b1;
        result_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (left == 0) begin
        mode      = $urandom_range(0, 2);
        left      = $urandom_range(20, 200);
        stall_pat = 16'($urandom()) | 16'h1;
      end
      left--;
      case (mode)
        0: result_ready_i <= 1'b1;
        1: result_ready_i <= 1'($urandom_range(0, 1));
        default: begin
          result_ready_i <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(status_o), word_start_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (word_start_o != want.word_start) begin
          report_mismatch("word_start", word_start_o, want.word_start);
        end
      end
    end
  end

  initial begin : watchdog
    #(TimeLimit);
    $display("Mismatches found");
    $finish;
  end

endmodule
